// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker file of the wildcard matcher.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, quiet while reset is asserted.
`define WPM_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error(msg);

// Clocked assertion that also holds through reset.
`define WPM_ASSERT_ALWAYS(name, prop, msg) \
	name: assert property (@(posedge clk) prop) \
	else $error(msg);

`endif

// ----- hw/rtl/wpm_pkg.sv -----
// ----------------------------------------------------------------------------
// wpm_pkg
// Constants, register map and character helpers of the wildcard matcher.
// ----------------------------------------------------------------------------
package wpm_pkg;

	localparam int DEF_MAX_PATTERN = 32;
	localparam int PAT_WORDS       = 4;
	localparam int CHARS_PER_WORD  = 8;
	localparam int WORD_W          = 64;
	localparam int LEN_W           = 6;
	localparam int PADDR_W         = 6;
	localparam int QUEUE_DEPTH     = 4;

	// register indexes (byte address is 8 * index)
	localparam logic [2:0] REG_WORD0  = 3'd0;
	localparam logic [2:0] REG_WORD1  = 3'd1;
	localparam logic [2:0] REG_WORD2  = 3'd2;
	localparam logic [2:0] REG_WORD3  = 3'd3;
	localparam logic [2:0] REG_LENGTH = 3'd4;

	// pattern metacharacters
	localparam logic [7:0] CHAR_STAR  = 8'h2A;
	localparam logic [7:0] CHAR_ANY   = 8'h3F;
	localparam logic [7:0] CHAR_DIGIT = 8'h23;

	localparam logic [7:0] CHAR_UC_A  = 8'h41;
	localparam logic [7:0] CHAR_UC_Z  = 8'h5A;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;
	localparam logic [7:0] CASE_DELTA = 8'h20;

	function automatic logic [7:0] fold_case(input logic [7:0] c);
		return (c >= CHAR_UC_A && c <= CHAR_UC_Z) ? c + CASE_DELTA : c;
	endfunction

	// one pattern character against one target byte (star handled elsewhere)
	function automatic logic char_match(input logic [7:0] p, input logic [7:0] c);
		if (p == CHAR_ANY) begin
			return 1'b1;
		end
		if (p == CHAR_DIGIT) begin
			return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
		end
		return fold_case(p) == fold_case(c);
	endfunction

endpackage

// ----- hw/rtl/wpm_if.sv -----
// ----------------------------------------------------------------------------
// wpm_if
// Valid/ready channels of the wildcard matcher: target bytes in, verdicts out.
// ----------------------------------------------------------------------------
interface wpm_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] target_char;
	logic       char_present;
	logic       end_of_target;

	modport source (output valid, target_char, char_present, end_of_target, input ready);
	modport sink   (input valid, target_char, char_present, end_of_target, output ready);
endinterface

interface wpm_out_if;
	logic valid;
	logic ready;
	logic matched;

	modport source (output valid, matched, input ready);
	modport sink   (input valid, matched, output ready);
endinterface

// ----- hw/rtl/wildcard_pattern_matcher.sv -----
// Final-beat verdicts pass the front register, the queue and the output register.
// Throughput: one target beat per cycle while the queue has room (NFA vector update).
// A stalled result parks in the output register; the 4-entry queue keeps input flowing.
// Reset (arst_n low, asynchronous): pattern registers clear to zero, only the start
// position is active, queue and output are empty.
// ----------------------------------------------------------------------------
// wildcard_pattern_matcher
// Streams a target string byte by byte and judges it against a glob pattern
// ('*', '?', '#', case-folded literals) held in APB registers.
// ----------------------------------------------------------------------------
module wildcard_pattern_matcher
	import wpm_pkg::*;
#(
	parameter int MAX_PATTERN = DEF_MAX_PATTERN
) (
	input  logic               clk,
	input  logic               arst_n,
	wpm_in_if.sink             target,
	wpm_out_if.source          result,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [WORD_W-1:0]  pwdata,
	output logic [WORD_W-1:0]  prdata,
	output logic               pready
);

	localparam int LW = $clog2(MAX_PATTERN + 1);
	localparam int QW = MAX_PATTERN + 2;

	// Configuration registers
	logic [WORD_W-1:0]           pattern_word_q [PAT_WORDS];
	logic [LEN_W-1:0]            pattern_length_q;
	logic [2:0]                  reg_idx;
	logic                        wr_en;
	logic [MAX_PATTERN-1:0][7:0] pattern;
	logic [LW-1:0]               pat_len;

	// Front to queue
	logic                   fr_valid;
	logic                   fr_ready;
	logic                   fr_present;
	logic                   fr_last;
	logic [MAX_PATTERN-1:0] fr_hit;

	// Queue to back
	logic                   bk_valid;
	logic                   bk_pop;
	logic [QW-1:0]          bk_data;

	// APB: always ready, write lands on the access phase
	assign pready  = 1'b1;
	assign reg_idx = paddr[5:3];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int w = 0; w < PAT_WORDS; w++) begin
				pattern_word_q[w] <= '0;
			end
			pattern_length_q <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				REG_WORD0:  pattern_word_q[0] <= pwdata;
				REG_WORD1:  pattern_word_q[1] <= pwdata;
				REG_WORD2:  pattern_word_q[2] <= pwdata;
				REG_WORD3:  pattern_word_q[3] <= pwdata;
				REG_LENGTH: pattern_length_q  <= pwdata[LEN_W-1:0];
				default:    ; // drop writes outside the map
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_WORD0:  prdata = pattern_word_q[0];
			REG_WORD1:  prdata = pattern_word_q[1];
			REG_WORD2:  prdata = pattern_word_q[2];
			REG_WORD3:  prdata = pattern_word_q[3];
			REG_LENGTH: prdata = WORD_W'(pattern_length_q);
			default:    prdata = '0;
		endcase
	end

	// Unpack pattern characters, lowest byte of each word first
	for (genvar g = 0; g < MAX_PATTERN; g++) begin : g_pat
		assign pattern[g] = pattern_word_q[g / CHARS_PER_WORD][(g % CHARS_PER_WORD) * 8 +: 8];
	end

	function automatic logic [LW-1:0] pat_len_trunc(input logic [LEN_W-1:0] n);
		return n[LW-1:0];
	endfunction

	// Clamp the programmed length to what the position vector can hold
	assign pat_len = (pattern_length_q > LEN_W'(MAX_PATTERN)) ? LW'(MAX_PATTERN)
	                                                        : pat_len_trunc(pattern_length_q);

	// Front: accept beats, register per-position hit vector
	wpm_front #(
		.MAX_PATTERN (MAX_PATTERN)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.target       (target),
		.pattern      (pattern),
		.item_valid   (fr_valid),
		.item_ready   (fr_ready),
		.item_present (fr_present),
		.item_last    (fr_last),
		.item_hit     (fr_hit)
	);

	// Queue: decouple the classify front from the NFA back
	wpm_queue #(
		.WIDTH (QW),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fr_valid),
		.push_ready (fr_ready),
		.push_data  ({fr_present, fr_last, fr_hit}),
		.pop_valid  (bk_valid),
		.pop        (bk_pop),
		.pop_data   (bk_data)
	);

	// Back: advance the active position vector, emit verdict on the final beat
	wpm_back #(
		.MAX_PATTERN (MAX_PATTERN)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.pattern      (pattern),
		.pat_len      (pat_len),
		.item_valid   (bk_valid),
		.item_pop     (bk_pop),
		.item_present (bk_data[QW-1]),
		.item_last    (bk_data[QW-2]),
		.item_hit     (bk_data[MAX_PATTERN-1:0]),
		.result       (result)
	);

endmodule

// ----- hw/rtl/wpm_queue.sv -----
// ----------------------------------------------------------------------------
// wpm_queue
// Small FIFO between the classify front and the NFA back.
// ----------------------------------------------------------------------------
module wpm_queue
	import wpm_pkg::*;
#(
	parameter int WIDTH = DEF_MAX_PATTERN + 2,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != CW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;
	assign pop_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- hw/rtl/wpm_front.sv -----
// ----------------------------------------------------------------------------
// wpm_front
// Accept target beats and classify the byte against every pattern position.
// ----------------------------------------------------------------------------
module wpm_front
	import wpm_pkg::*;
#(
	parameter int MAX_PATTERN = DEF_MAX_PATTERN
) (
	input  logic                        clk,
	input  logic                        arst_n,
	wpm_in_if.sink                      target,
	input  logic [MAX_PATTERN-1:0][7:0] pattern,
	output logic                        item_valid,
	input  logic                        item_ready,
	output logic                        item_present,
	output logic                        item_last,
	output logic [MAX_PATTERN-1:0]      item_hit
);

	logic                   valid_s1;
	logic                   present_s1;
	logic                   last_s1;
	logic [MAX_PATTERN-1:0] hit_s1;
	logic                   take;

	assign target.ready = !valid_s1 || item_ready;
	assign take         = target.valid && target.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (target.ready) begin
			valid_s1 <= target.valid;
		end
	end

	// per-position hit: literal, '?' or '#' class versus this byte
	always_ff @(posedge clk) begin
		if (take) begin
			present_s1 <= target.char_present;
			last_s1    <= target.end_of_target;
			for (int i = 0; i < MAX_PATTERN; i++) begin
				hit_s1[i] <= char_match(pattern[i], target.target_char);
			end
		end
	end

	assign item_valid   = valid_s1;
	assign item_present = present_s1;
	assign item_last    = last_s1;
	assign item_hit     = hit_s1;

endmodule

// ----- hw/rtl/wpm_back.sv -----
// ----------------------------------------------------------------------------
// wpm_back
// NFA position vector update with star closure, and the verdict register.
// ----------------------------------------------------------------------------
module wpm_back
	import wpm_pkg::*;
#(
	parameter int MAX_PATTERN = DEF_MAX_PATTERN,
	localparam int LW = $clog2(MAX_PATTERN + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [MAX_PATTERN-1:0][7:0] pattern,
	input  logic [LW-1:0]               pat_len,
	input  logic                        item_valid,
	output logic                        item_pop,
	input  logic                        item_present,
	input  logic                        item_last,
	input  logic [MAX_PATTERN-1:0]      item_hit,
	wpm_out_if.source                   result
);

	localparam int NS = MAX_PATTERN + 1;

	logic [NS-1:0]          state_q;
	logic                   out_valid_q;
	logic                   matched_q;
	logic [MAX_PATTERN-1:0] is_star;
	logic [MAX_PATTERN-1:0] below_len;
	logic [NS-1:0]          in_mask;
	logic [NS-1:0]          star_p;
	logic [NS-1:0]          v_open;
	logic [MAX_PATTERN-1:0] adv;
	logic [NS-1:0]          v_step;
	logic [NS-1:0]          v_consumed;
	logic [NS-1:0]          v_next;
	logic                   out_free;

	// epsilon closure over star runs as a prefix OR, log2 levels
	function automatic logic [NS-1:0] closure(input logic [NS-1:0] v, input logic [NS-1:0] p);
		logic [NS-1:0] g;
		logic [NS-1:0] pp;
		g  = v;
		pp = p;
		for (int d = 1; d < NS; d = d * 2) begin
			g  = g | ((g & pp) << d);
			pp = pp & (pp >> d);
		end
		return g;
	endfunction

	always_comb begin
		for (int i = 0; i < MAX_PATTERN; i++) begin
			is_star[i]   = (pattern[i] == CHAR_STAR);
			below_len[i] = (LW'(i) < pat_len);
		end
		for (int i = 0; i < NS; i++) begin
			in_mask[i] = (LW'(i) <= pat_len);
		end
		star_p     = {1'b0, is_star & below_len};
		v_open     = closure(state_q, star_p) & in_mask;
		adv        = v_open[MAX_PATTERN-1:0] & below_len & ~is_star & item_hit;
		v_step     = (v_open & star_p) | {adv, 1'b0};
		v_consumed = closure(v_step, star_p) & in_mask;
		v_next     = item_present ? v_consumed : v_open;
	end

	assign out_free = !out_valid_q || result.ready;
	assign item_pop = item_valid && (!item_last || out_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= NS'(1);
			out_valid_q <= 1'b0;
		end else begin
			if (item_pop) begin
				state_q <= item_last ? NS'(1) : v_next;
			end
			if (item_pop && item_last) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_pop && item_last) begin
			matched_q <= v_next[pat_len];
		end
	end

	assign result.valid   = out_valid_q;
	assign result.matched = matched_q;

endmodule

// ----- hw/rtl/wpm_checker.sv -----
// ----------------------------------------------------------------------------
// wpm_checker
// Port-level checks of the wildcard matcher, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wpm_checker (
	input logic clk,
	input logic arst_n,
	input logic tgt_valid,
	input logic tgt_ready,
	input logic tgt_last,
	input logic res_valid,
	input logic res_ready,
	input logic res_matched,
	input logic pready
);

	// final beats taken whose verdict has not been delivered yet
	logic [2:0] owed_q;
	logic       last_in;
	logic       res_out;

	assign last_in = tgt_valid && tgt_ready && tgt_last;
	assign res_out = res_valid && res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owed_q <= '0;
		end else begin
			case ({last_in, res_out})
				2'b10:   owed_q <= owed_q + 1'b1;
				2'b01:   owed_q <= owed_q - 1'b1;
				default: owed_q <= owed_q;
			endcase
		end
	end

	`WPM_ASSERT(a_res_hold, res_valid && !res_ready |=> res_valid, "verdict dropped while stalled")
	`WPM_ASSERT(a_res_stable, res_valid && !res_ready |=> $stable(res_matched), "verdict changed while stalled")
	`WPM_ASSERT(a_res_owed, res_valid |-> owed_q != 3'd0, "verdict without a final beat")
	`WPM_ASSERT(a_owed_cap, owed_q <= 3'd6, "more final beats in flight than the pipeline holds")
	`WPM_ASSERT_ALWAYS(a_pready, pready, "config port not ready")

endmodule

bind wildcard_pattern_matcher wpm_checker u_wpm_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.tgt_valid   (target.valid),
	.tgt_ready   (target.ready),
	.tgt_last    (target.end_of_target),
	.res_valid   (result.valid),
	.res_ready   (result.ready),
	.res_matched (result.matched),
	.pready      (pready)
);

// ----- verif/tb_wildcard_pattern_matcher.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_wildcard_pattern_matcher
// Self-checking bench for the streaming glob matcher. Patterns go in over
// APB, target strings stream in one byte per beat, and every verdict is
// compared in order against a bit-parallel NFA predictor kept in a
// scoreboard. Sender gaps and receiver stalls come in random bursts.
// ----------------------------------------------------------------------------

class verdict_scoreboard;

	logic [wpm_pkg::WORD_W-1:0] pat_word [wpm_pkg::PAT_WORDS];
	logic [wpm_pkg::LEN_W-1:0]  pat_len_reg;
	logic [32:0]                live_pos;
	bit                         expected_verdicts [$];
	int unsigned                mismatches;
	int unsigned                verdicts_checked;
	int unsigned                matches_seen;

	function new();
		foreach (pat_word[w]) pat_word[w] = '0;
		pat_len_reg      = '0;
		live_pos         = 33'd1;
		mismatches       = 0;
		verdicts_checked = 0;
		matches_seen     = 0;
	endfunction

	function void write_reg(input logic [2:0] idx, input logic [wpm_pkg::WORD_W-1:0] val);
		case (idx)
			wpm_pkg::REG_WORD0, wpm_pkg::REG_WORD1,
			wpm_pkg::REG_WORD2, wpm_pkg::REG_WORD3: begin
				pat_word[idx[1:0]] = val;
			end
			wpm_pkg::REG_LENGTH: begin
				pat_len_reg = val[wpm_pkg::LEN_W-1:0];
			end
			default: begin
			end
		endcase
	endfunction

	function int eff_len();
		int n;
		n = pat_len_reg;
		if (n > wpm_pkg::DEF_MAX_PATTERN) n = wpm_pkg::DEF_MAX_PATTERN;
		return n;
	endfunction

	function logic [7:0] pat_at(input int i);
		return pat_word[i / 8][(i % 8) * 8 +: 8];
	endfunction

	function logic [7:0] lower(input logic [7:0] c);
		if (c >= wpm_pkg::CHAR_UC_A && c <= wpm_pkg::CHAR_UC_Z) return c + wpm_pkg::CASE_DELTA;
		return c;
	endfunction

	function bit byte_hits(input logic [7:0] p, input logic [7:0] c);
		if (p == wpm_pkg::CHAR_ANY) return 1'b1;
		if (p == wpm_pkg::CHAR_DIGIT) return c >= wpm_pkg::CHAR_ZERO && c <= wpm_pkg::CHAR_NINE;
		return lower(p) == lower(c);
	endfunction

	// a star lets its position also enable the next one; positions past the
	// pattern end are dropped
	function logic [32:0] star_close(input logic [32:0] v, input int len);
		for (int i = 0; i < len; i++) begin
			if (v[i] && pat_at(i) == wpm_pkg::CHAR_STAR) v[i + 1] = 1'b1;
		end
		for (int i = len + 1; i <= 32; i++) v[i] = 1'b0;
		return v;
	endfunction

	function void note_beat(input logic [7:0] ch, input logic present, input logic last);
		int          len;
		logic [32:0] v;
		logic [32:0] nxt;
		len = eff_len();
		v   = star_close(live_pos, len);
		if (present) begin
			nxt = '0;
			for (int i = 0; i < len; i++) begin
				if (v[i]) begin
					if (pat_at(i) == wpm_pkg::CHAR_STAR) nxt[i] = 1'b1;
					else if (byte_hits(pat_at(i), ch)) nxt[i + 1] = 1'b1;
				end
			end
			v = star_close(nxt, len);
		end
		if (last) begin
			expected_verdicts.push_back(v[len]);
			live_pos = 33'd1;
		end else begin
			live_pos = v;
		end
	endfunction

	function void check_verdict(input logic matched);
		bit want;
		verdicts_checked++;
		if (matched === 1'b1) matches_seen++;
		if (expected_verdicts.size() == 0) begin
			mismatches++;
			if (mismatches <= 10) $display("verdict with nothing pending: got %0b", matched);
			return;
		end
		want = expected_verdicts.pop_front();
		if (matched !== want) begin
			mismatches++;
			if (mismatches <= 10)
				$display("verdict mismatch %0d: expected matched=%0b, got %0b",
					verdicts_checked, want, matched);
		end
	endfunction

	function int unsigned pending();
		return expected_verdicts.size();
	endfunction

endclass

module tb_wildcard_pattern_matcher;
	import wpm_pkg::*;

	localparam int ITEM_GOAL      = 1400;
	localparam int SETTLE_CYCLES  = 4;	// settle margin after the last verdict
	localparam int WATCHDOG_LIMIT = 2000;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [WORD_W-1:0]  pwdata;
	logic [WORD_W-1:0]  prdata;
	logic               pready;
	logic               rx_ready = 1'b0;

	wpm_in_if  target_ch ();
	wpm_out_if result_ch ();

	assign result_ch.ready = rx_ready;

	wildcard_pattern_matcher DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.target  (target_ch),
		.result  (result_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	verdict_scoreboard board;

	bit          idle_on = 1'b1;	// random gaps and stalls; dropped for the tail of the run
	int unsigned beats_sent;	// beats that consume a byte or close a string
	int unsigned strings_sent;
	int unsigned settings_used;
	int unsigned stall_left = 0;
	int unsigned quiet_cycles = 0;
	logic [7:0]  cur_pattern [DEF_MAX_PATTERN];
	int          cur_len;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Observe both channels at the edge: the values seen here are the ones the
	// block sampled, since every driver updates through nonblocking assignments.
	always @(posedge clk) begin
		if (arst_n) begin
			if (target_ch.valid && target_ch.ready)
				board.note_beat(target_ch.target_char, target_ch.char_present,
					target_ch.end_of_target);
			if (result_ch.valid && result_ch.ready)
				board.check_verdict(result_ch.matched);
		end
	end

	// Receiver: while idle_on is set, hold ready low in bursts of random length, otherwise accept.
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			rx_ready   <= 1'b0;
			stall_left <= $urandom_range(0, 4);
		end else begin
			rx_ready <= 1'b1;
		end
	end

	// Watchdog: any beat on either channel or an APB access counts as progress.
	always @(posedge clk) begin
		if ((target_ch.valid && target_ch.ready) || (result_ch.valid && result_ch.ready) ||
				(psel && penable)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
			$display("Regression FAIL");
			$finish;
		end
	end

	// One APB write: setup, access, then the bus is released.
	task automatic apb_write(input logic [2:0] idx, input logic [WORD_W-1:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 3'b000};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		board.write_reg(idx, val);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Load cur_pattern into the four pattern words, then the length.
	task automatic program_pattern(input logic [LEN_W-1:0] len_val);
		logic [WORD_W-1:0] word;
		for (int w = 0; w < PAT_WORDS; w++) begin
			for (int c = 0; c < CHARS_PER_WORD; c++)
				word[c * 8 +: 8] = cur_pattern[w * CHARS_PER_WORD + c];
			apb_write(REG_WORD0 + 3'(w), word);
		end
		apb_write(REG_LENGTH, WORD_W'(len_val));
		cur_len = (len_val > DEF_MAX_PATTERN) ? DEF_MAX_PATTERN : int'(len_val);
		settings_used++;
	endtask

	// Offer one beat and hold it until accepted; valid stays high afterwards so
	// that the next call can follow back to back.
	task automatic send_beat(input logic [7:0] ch, input logic present, input logic last);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			target_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		target_ch.valid         <= 1'b1;
		target_ch.target_char   <= ch;
		target_ch.char_present  <= present;
		target_ch.end_of_target <= last;
		@(posedge clk);
		while (!target_ch.ready) @(posedge clk);
		if (present || last) beats_sent++;
		if (last) strings_sent++;
	endtask

	task automatic send_text(input string s, input bit close);
		for (int i = 0; i < s.len(); i++)
			send_beat(s[i], 1'b1, close && i == s.len() - 1);
	endtask

	// Stream a whole string; sometimes close it with an empty beat instead of
	// marking the last byte, and sprinkle absent bytes that must be ignored.
	task automatic send_string(input logic [7:0] text [$]);
		bit tail_empty;
		tail_empty = text.size() == 0 || $urandom_range(0, 4) == 0;
		foreach (text[i]) begin
			if ($urandom_range(0, 9) == 0) send_beat(8'($urandom), 1'b0, 1'b0);
			send_beat(text[i], 1'b1, !tail_empty && i == text.size() - 1);
		end
		if (tail_empty) send_beat(8'($urandom), 1'b0, 1'b1);
	endtask

	// Drop valid and wait until every verdict is in and the pipe has settled.
	task automatic drain_results();
		target_ch.valid <= 1'b0;
		@(posedge clk);
		while (board.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [7:0] random_text_byte();
		logic [7:0] c;
		case ($urandom_range(0, 3))
			0: c = 8'($urandom);
			1: c = CHAR_ZERO + 8'($urandom_range(0, 9));
			default: begin
				c = "a" + 8'($urandom_range(0, 3));
				if ($urandom_range(0, 1) == 1) c = c - CASE_DELTA;
			end
		endcase
		return c;
	endfunction

	function automatic logic [7:0] random_pattern_byte();
		case ($urandom_range(0, 9))
			0, 1: return CHAR_STAR;
			2:    return CHAR_ANY;
			3:    return CHAR_DIGIT;
			default: return random_text_byte();
		endcase
	endfunction

	initial begin : stimulus
		string      dir_pat;
		logic [7:0] text [$];
		logic [7:0] p;
		int         pick;
		int         plen;
		int         pos;
		int         phase_end;
		logic [5:0] len_val;

		board = new();
		// Drive every input to a known value before the first edge.
		arst_n                  = 1'b0;
		psel                    = 1'b0;
		penable                 = 1'b0;
		pwrite                  = 1'b0;
		paddr                   = '0;
		pwdata                  = '0;
		target_ch.valid         = 1'b0;
		target_ch.target_char   = '0;
		target_ch.char_present  = 1'b0;
		target_ch.end_of_target = 1'b0;
		cur_len                 = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Out of reset the pattern is empty: only the empty target matches.
		send_beat(8'($urandom), 1'b0, 1'b1);
		send_text("a", 1'b1);

		// Literals in both cases, any-char, digit class and a star next to the end.
		drain_results();
		dir_pat = "A?#*z";
		for (int i = 0; i < DEF_MAX_PATTERN; i++)
			cur_pattern[i] = (i < dir_pat.len()) ? dir_pat[i] : 8'($urandom);
		program_pattern(6'd5);
		send_beat("a", 1'b1, 1'b0);
		send_beat(8'($urandom), 1'b0, 1'b0);	// absent byte mid-string: no effect
		send_text("x7Z", 1'b1);
		send_text("Ab9xyZ", 1'b1);
		send_text("aa:z", 1'b1);	// dies on the digit class

		// Shorten the pattern in the middle of a string; progress must carry over.
		send_text("ax", 1'b0);
		drain_results();
		apb_write(REG_LENGTH, WORD_W'(3));
		send_text("5", 1'b1);

		// A zero byte in the pattern only matches a present zero byte.
		drain_results();
		cur_pattern[0] = CHAR_STAR;
		cur_pattern[1] = 8'h00;
		program_pattern(6'd2);
		send_beat(8'h00, 1'b1, 1'b1);
		send_beat(8'h00, 1'b0, 1'b1);

		// Oversized length clamps to a full pattern of stars: the empty target matches.
		drain_results();
		for (int i = 0; i < DEF_MAX_PATTERN; i++) cur_pattern[i] = CHAR_STAR;
		program_pattern(6'd63);
		send_beat(8'($urandom), 1'b0, 1'b1);

		// Random phases: a fresh pattern, then strings built to follow it, most
		// of them intact, some damaged, a few plain noise. Every phase boundary
		// waits for all verdicts before reprogramming.
		while (beats_sent < ITEM_GOAL) begin
			drain_results();
			if (beats_sent >= ITEM_GOAL * 85 / 100) idle_on = 1'b0;
			pick = $urandom_range(0, 9);
			if (pick < 7) begin
				plen    = $urandom_range(0, 8);
				len_val = 6'(plen);
			end else if (pick < 9) begin
				plen    = $urandom_range(9, 31);
				len_val = 6'(plen);
			end else begin
				plen    = DEF_MAX_PATTERN;
				len_val = 6'($urandom_range(32, 63));
			end
			for (int i = 0; i < DEF_MAX_PATTERN; i++)
				cur_pattern[i] = (i < plen) ? random_pattern_byte() : 8'($urandom);
			program_pattern(len_val);

			phase_end = beats_sent + $urandom_range(20, 50);
			while (beats_sent < phase_end) begin
				text = {};
				if ($urandom_range(0, 9) == 0) begin
					repeat ($urandom_range(0, 8)) text.push_back(8'($urandom));
				end else begin
					for (int i = 0; i < cur_len; i++) begin
						p = cur_pattern[i];
						if (p == CHAR_STAR) begin
							repeat ($urandom_range(0, 3)) text.push_back(random_text_byte());
						end else if (p == CHAR_ANY) begin
							text.push_back(random_text_byte());
						end else if (p == CHAR_DIGIT) begin
							text.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
						end else begin
							// flip the case of letters half the time
							if ((p | CASE_DELTA) >= "a" && (p | CASE_DELTA) <= "z" &&
									$urandom_range(0, 1) == 1)
								p = p ^ CASE_DELTA;
							text.push_back(p);
						end
					end
					// damage a quarter of them: replace, drop or insert one byte
					if ($urandom_range(0, 3) == 0) begin
						pos = $urandom_range(0, text.size());
						case ($urandom_range(0, 2))
							0: if (pos < text.size()) text[pos] = random_text_byte();
							1: if (pos < text.size()) text.delete(pos);
							default: text.insert(pos, random_text_byte());
						endcase
					end
				end
				send_string(text);
			end
		end

		// Tail: release the input and wait for the last verdicts to drain.
		target_ch.valid <= 1'b0;
		@(posedge clk);
		while (board.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("Streamed %0d beats in %0d strings across %0d pattern settings.",
			beats_sent, strings_sent, settings_used);
		$display("Checked %0d verdicts, %0d of them matches; %0d mismatches, %0d still pending.",
			board.verdicts_checked, board.matches_seen, board.mismatches, board.pending());
		if (board.mismatches == 0 && board.pending() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
